// ===== hw/rtl/lbfc_pkg.sv =====
// Shared types, constants and constant-divide helpers for the bitrate/FEC controller.
package lbfc_pkg;

    localparam int RATE_W = 30;
    localparam int LOSS_W = 7;
    localparam int TIME_W = 64;
    localparam int CNT_W  = 3;
    localparam int IDX_W  = 2;

    // Decision thresholds
    localparam logic [LOSS_W-1:0] FEC_ON_LOSS = 7'd1;
    localparam logic [LOSS_W-1:0] LIGHT_LOSS  = 7'd2;
    localparam logic [LOSS_W-1:0] HEAVY_LOSS  = 7'd5;
    localparam logic [CNT_W-1:0]  FEC_OFF_CLEAN = 3'd5;
    localparam logic [TIME_W-1:0] HOLD_US = 64'd2000000;
    localparam int HEAVY_SHIFT = 2;
    localparam int STEP_DIV    = 20;

    // Register reset values
    localparam logic [RATE_W-1:0] RESET_MIN_RATE   = 30'd500000;
    localparam logic [RATE_W-1:0] RESET_MAX_RATE   = 30'd20000000;
    localparam logic [RATE_W-1:0] RESET_START_RATE = 30'd8000000;
    localparam logic [RATE_W-1:0] RESET_STEP       = RATE_W'(RESET_MAX_RATE / STEP_DIV);

    // Reciprocal constants: q = (x * MUL) >> SHIFT, exact for any 30-bit x
    localparam logic [30:0] DIV10_MUL   = 31'd1717986919;
    localparam int          DIV10_SHIFT = 34;
    localparam logic [30:0] DIV20_MUL   = 31'd1717986919;
    localparam int          DIV20_SHIFT = 35;
    localparam logic [30:0] DIV50_MUL   = 31'd687194768;
    localparam int          DIV50_SHIFT = 35;

    typedef enum logic [IDX_W-1:0] {
        CFG_MIN_RATE   = 2'd0,
        CFG_MAX_RATE   = 2'd1,
        CFG_START_RATE = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [LOSS_W-1:0] loss_pct;
        logic [TIME_W-1:0] now_us;
    } rpt_t;

    typedef struct packed {
        logic              fec_enabled;
        logic              fec_toggled;
        logic              change_bitrate;
        logic [RATE_W-1:0] bitrate_bps;
    } res_t;

    // Configuration view handed to the decision logic
    typedef struct packed {
        logic [RATE_W-1:0] min_rate;
        logic [RATE_W-1:0] max_rate;
        logic [RATE_W-1:0] step;
        logic              start_load;
        logic [RATE_W-1:0] start_value;
    } cfg_t;

    function automatic logic [RATE_W-1:0] div10(input logic [RATE_W-1:0] x);
        logic [63:0] prod;
        prod = 64'(x) * 64'(DIV10_MUL);
        return RATE_W'(prod >> DIV10_SHIFT);
    endfunction

    function automatic logic [RATE_W-1:0] div20(input logic [RATE_W-1:0] x);
        logic [63:0] prod;
        prod = 64'(x) * 64'(DIV20_MUL);
        return RATE_W'(prod >> DIV20_SHIFT);
    endfunction

    function automatic logic [RATE_W-1:0] div50(input logic [RATE_W-1:0] x);
        logic [63:0] prod;
        prod = 64'(x) * 64'(DIV50_MUL);
        return RATE_W'(prod >> DIV50_SHIFT);
    endfunction

endpackage

// ===== hw/rtl/lbfc_cfg.sv =====
// Configuration registers: rate clamps, precomputed increase step, start-rate load.
module lbfc_cfg
    import lbfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_index,
    input  logic [RATE_W-1:0] wr_data,
    output cfg_t              cfg
);

    logic [RATE_W-1:0] min_reg, min_next;
    logic [RATE_W-1:0] max_reg, max_next;
    logic [RATE_W-1:0] step_reg, step_next;
    logic              start_load;

    // Decode a write request
    always_comb
    begin
        min_next   = min_reg;
        max_next   = max_reg;
        step_next  = step_reg;
        start_load = 1'b0;
        if (wr_en)
        begin
            unique case (cfg_idx_t'(wr_index))
                CFG_MIN_RATE:   min_next = wr_data;
                CFG_MAX_RATE:
                begin
                    max_next  = wr_data;
                    step_next = div20(wr_data);
                end
                CFG_START_RATE: start_load = 1'b1;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg  <= RESET_MIN_RATE;
            max_reg  <= RESET_MAX_RATE;
            step_reg <= RESET_STEP;
        end
        else
        begin
            min_reg  <= min_next;
            max_reg  <= max_next;
            step_reg <= step_next;
        end
    end

    assign cfg.min_rate    = min_reg;
    assign cfg.max_rate    = max_reg;
    assign cfg.step        = step_reg;
    assign cfg.start_load  = start_load;
    assign cfg.start_value = wr_data;

endmodule

// ===== hw/rtl/lbfc_ctrl.sv =====
// Controller state and the single-pass FEC and AIMD rate decision.
module lbfc_ctrl
    import lbfc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  rpt_t rpt,
    input  logic commit,
    input  cfg_t cfg,
    output res_t res
);

    logic              fec_reg, fec_next;
    logic [CNT_W-1:0]  clean_reg, clean_next;
    logic [TIME_W-1:0] last_dec_reg;
    logic [RATE_W-1:0] cur_reg;

    logic              fec_loss, heavy, light, hold_done, decrease;
    logic [TIME_W-1:0] elapsed;
    logic [RATE_W:0]   cand;
    logic [RATE_W-1:0] capped, clamped, delta;
    logic              change;

    // FEC on at any loss, off after enough clean reports
    always_comb
    begin
        fec_loss = (rpt.loss_pct >= FEC_ON_LOSS);
        if (fec_loss)
        begin
            clean_next = '0;
            fec_next   = 1'b1;
        end
        else
        begin
            clean_next = (clean_reg < FEC_OFF_CLEAN) ? clean_reg + 1'b1 : clean_reg;
            fec_next   = (clean_next >= FEC_OFF_CLEAN) ? 1'b0 : fec_reg;
        end
    end

    // Candidate rate: multiplicative decrease or additive increase
    always_comb
    begin
        heavy     = (rpt.loss_pct >= HEAVY_LOSS);
        light     = (rpt.loss_pct >= LIGHT_LOSS);
        decrease  = heavy || light;
        elapsed   = rpt.now_us - last_dec_reg;
        hold_done = (elapsed > HOLD_US);
        priority if (heavy)
            cand = {1'b0, cur_reg - (cur_reg >> HEAVY_SHIFT)};
        else if (light)
            cand = {1'b0, cur_reg - div10(cur_reg)};
        else if (hold_done)
            cand = {1'b0, cur_reg} + {1'b0, cfg.step};
        else
            cand = {1'b0, cur_reg};
    end

    // Clamp (max first, min wins) and deadband
    always_comb
    begin
        capped  = (cand > {1'b0, cfg.max_rate}) ? cfg.max_rate : cand[RATE_W-1:0];
        clamped = (capped < cfg.min_rate) ? cfg.min_rate : capped;
        delta   = (clamped > cur_reg) ? clamped - cur_reg : cur_reg - clamped;
        change  = (clamped != cur_reg) && (delta >= div50(cur_reg));
    end

    assign res.fec_enabled    = fec_next;
    assign res.fec_toggled    = fec_next ^ fec_reg;
    assign res.change_bitrate = change;
    assign res.bitrate_bps    = change ? clamped : cur_reg;

    // State update when the report moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fec_reg      <= 1'b0;
            clean_reg    <= '0;
            last_dec_reg <= '0;
            cur_reg      <= RESET_START_RATE;
        end
        else if (cfg.start_load)
        begin
            cur_reg <= cfg.start_value;
        end
        else if (commit)
        begin
            fec_reg   <= fec_next;
            clean_reg <= clean_next;
            if (decrease)
                last_dec_reg <= rpt.now_us;
            if (change)
                cur_reg <= clamped;
        end
    end

endmodule

// ===== hw/rtl/loss_based_bitrate_and_fec_control_unit.sv =====
// Top level: report register, decision logic and result register.
// Loss-based bitrate and FEC controller. Each feedback request (loss_pct,
// now_us) yields exactly one result. A request is captured in an input
// register and evaluated by the combinational decision logic, which updates
// the controller state as the result is written to the output register;
// res_valid rises once the output register takes the result, which can wait
// while a held result is stalled, and one request per cycle is sustained
// while res_ready is high. The output register keeps a finished result
// while the next request waits in the input register.
// Registers (cfg_index): 0 min_bitrate, 1 max_bitrate, 2 start_bitrate;
// writing start_bitrate only loads the current rate. cfg_ready is always high.
module loss_based_bitrate_and_fec_control_unit
    import lbfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rpt_valid,
    output logic              rpt_ready,
    input  rpt_t              rpt,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [RATE_W-1:0] cfg_data
);

    logic s1_valid_reg;
    rpt_t s1_reg;
    logic res_valid_reg;
    res_t res_reg;
    logic advance;
    cfg_t cfg;
    res_t res_next;

    assign cfg_ready = 1'b1;

    lbfc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Stage hand-off
    assign advance   = s1_valid_reg && (!res_valid_reg || res_ready);
    assign rpt_ready = !s1_valid_reg || advance;

    lbfc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .rpt    (s1_reg),
        .commit (advance),
        .cfg    (cfg),
        .res    (res_next)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (rpt_ready)
                s1_valid_reg <= rpt_valid;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (rpt_valid && rpt_ready)
            s1_reg <= rpt;
        if (advance)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== hw/rtl/lbfc_checker.sv =====
// Port-level checks for the controller top level, bound to it.
module lbfc_checker
    import lbfc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic rpt_valid,
    input logic rpt_ready,
    input logic res_valid,
    input logic res_ready,
    input res_t res,
    input logic cfg_ready
);

    // A held result stays put
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // Requests are only refused while a result is stalled
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !rpt_ready |-> res_valid && !res_ready)
        else $error("request refused without output backpressure");

    // A request taken while no result is waiting is followed by a valid result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && rpt_ready && !res_valid |-> ##2 res_valid)
        else $error("result missing after request");

    // Register writes are never refused
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration write refused");

endmodule

bind loss_based_bitrate_and_fec_control_unit lbfc_checker u_lbfc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rpt_valid (rpt_valid),
    .rpt_ready (rpt_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_ready (cfg_ready)
);

// ===== bench/tb_loss_based_bitrate_and_fec_control_unit.sv =====
// Testbench for the loss-based bitrate and FEC controller: directed table, random reports.
module tb_loss_based_bitrate_and_fec_control_unit;
    import lbfc_pkg::*;

    // Rate arithmetic used by the local predictor
    localparam int unsigned HEAVY_CUT_DIV = 4;
    localparam int unsigned LIGHT_CUT_DIV = 10;
    localparam int unsigned RAISE_DIV     = 20;
    localparam int unsigned DEADBAND_DIV  = 50;
    localparam logic [RATE_W-1:0] RATE_TOP = 30'd1000000000;
    // Index with no register behind it; writes to it are dropped
    localparam logic [IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int unsigned PHASES        = 9;
    localparam int unsigned PHASE_ITEMS   = 120;
    localparam int unsigned LONG_HOLD     = 60;
    localparam int unsigned SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [LOSS_W-1:0] loss;
        logic [TIME_W-1:0] now;
        logic              pinned;
        res_t              want;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              rpt_valid = 1'b0;
    logic              rpt_ready;
    rpt_t              rpt = '0;
    logic              res_valid;
    logic              res_ready = 1'b0;
    res_t              res;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [RATE_W-1:0] cfg_data = '0;

    // Predictor copy of the controller state and registers
    logic [RATE_W-1:0] min_reg, max_reg, rate_st;
    logic              fec_st;
    logic [CNT_W-1:0]  clean_st;
    logic [TIME_W-1:0] last_dec_st;

    res_t              owed_results[$];
    res_t              predicted;
    res_t              owed;
    bit                pin_valid = 1'b0;
    res_t              pin_res = '0;
    dir_row_t          dir_tab[$];
    logic [TIME_W-1:0] feed_time_us = '0;
    int unsigned       tx_idle_pct = 0;
    int unsigned       rx_stall_pct = 0;
    int unsigned       sent_n = 0;
    int unsigned       got_n = 0;
    int unsigned       err_cnt = 0;
    int unsigned       rx_taken = 0;
    int unsigned       rx_hold = 0;

    loss_based_bitrate_and_fec_control_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rpt_valid (rpt_valid),
        .rpt_ready (rpt_ready),
        .rpt       (rpt),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        if (err_cnt < 40)
            $display("mismatch: %s", what);
        err_cnt++;
    endtask

    // One feedback report through the controller: FEC hysteresis, AIMD rate, clamp, deadband
    function automatic res_t decide_rate_fec(input rpt_t r);
        logic [63:0] cur, nxt, delta, elapsed;
        logic        fec_was;
        res_t        o;
        fec_was = fec_st;
        cur     = 64'(rate_st);
        nxt     = cur;
        elapsed = r.now_us - last_dec_st;
        if (r.loss_pct >= FEC_ON_LOSS)
        begin
            clean_st = '0;
            fec_st   = 1'b1;
        end
        else
        begin
            if (clean_st < FEC_OFF_CLEAN)
                clean_st = clean_st + 1'b1;
            if (clean_st >= FEC_OFF_CLEAN)
                fec_st = 1'b0;
        end
        if (r.loss_pct >= HEAVY_LOSS)
        begin
            nxt         = cur - cur / HEAVY_CUT_DIV;
            last_dec_st = r.now_us;
        end
        else if (r.loss_pct >= LIGHT_LOSS)
        begin
            nxt         = cur - cur / LIGHT_CUT_DIV;
            last_dec_st = r.now_us;
        end
        else if (elapsed > HOLD_US)
        begin
            nxt = cur + 64'(max_reg) / RAISE_DIV;
        end
        // max clamp first, so min wins when the two cross
        if (nxt > 64'(max_reg))
            nxt = 64'(max_reg);
        if (nxt < 64'(min_reg))
            nxt = 64'(min_reg);
        delta = (nxt > cur) ? nxt - cur : cur - nxt;
        o.change_bitrate = (nxt != cur) && (delta >= cur / DEADBAND_DIV);
        if (o.change_bitrate)
            rate_st = nxt[RATE_W-1:0];
        o.fec_enabled = fec_st;
        o.fec_toggled = (fec_st != fec_was);
        o.bitrate_bps = rate_st;
        return o;
    endfunction

    // Predictor update at each accepted request and register write
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            min_reg     <= RESET_MIN_RATE;
            max_reg     <= RESET_MAX_RATE;
            rate_st     <= RESET_START_RATE;
            fec_st      <= 1'b0;
            clean_st    <= '0;
            last_dec_st <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MIN_RATE:   min_reg = cfg_data;
                    CFG_MAX_RATE:   max_reg = cfg_data;
                    CFG_START_RATE: rate_st = cfg_data;
                    default: ;
                endcase
            end
            if (rpt_valid && rpt_ready)
            begin
                predicted = decide_rate_fec(rpt);
                owed_results.push_back(pin_valid ? pin_res : predicted);
            end
        end
    end

    // Result check against the oldest owed result
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            got_n++;
            if (owed_results.size() == 0)
            begin
                flag_mismatch("result arrived with none outstanding");
            end
            else
            begin
                owed = owed_results.pop_front();
                if (res.fec_enabled !== owed.fec_enabled)
                    flag_mismatch($sformatf("fec_enabled got %0b want %0b",
                        res.fec_enabled, owed.fec_enabled));
                if (res.fec_toggled !== owed.fec_toggled)
                    flag_mismatch($sformatf("fec_toggled got %0b want %0b",
                        res.fec_toggled, owed.fec_toggled));
                if (res.change_bitrate !== owed.change_bitrate)
                    flag_mismatch($sformatf("change_bitrate got %0b want %0b",
                        res.change_bitrate, owed.change_bitrate));
                if (res.bitrate_bps !== owed.bitrate_bps)
                    flag_mismatch($sformatf("bitrate_bps got %0d want %0d",
                        res.bitrate_bps, owed.bitrate_bps));
            end
        end
    end

    // Result side: random stalls, plus two long hold-offs so the input side backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            rx_taken  <= 0;
            rx_hold   <= 0;
        end
        else if (rx_hold != 0)
        begin
            res_ready <= 1'b0;
            rx_hold   <= rx_hold - 1;
        end
        else if (res_valid && res_ready && (rx_taken == 150 || rx_taken == 650))
        begin
            res_ready <= 1'b0;
            rx_hold   <= LONG_HOLD;
            rx_taken  <= rx_taken + 1;
        end
        else
        begin
            if (res_valid && res_ready)
                rx_taken <= rx_taken + 1;
            res_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic dir_row_t row(input int unsigned loss, input logic [63:0] now,
            input bit pinned, input bit fe, input bit ft, input bit cb,
            input int unsigned rate);
        dir_row_t d;
        d.loss                = LOSS_W'(loss);
        d.now                 = now;
        d.pinned              = pinned;
        d.want.fec_enabled    = fe;
        d.want.fec_toggled    = ft;
        d.want.change_bitrate = cb;
        d.want.bitrate_bps    = RATE_W'(rate);
        return d;
    endfunction

    // Mostly clean/lossy runs on a forward-moving clock; some jumps and hold-edge steps
    function automatic rpt_t next_random_report();
        rpt_t        r;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55)
            r.loss_pct = '0;
        else if (pick < 65)
            r.loss_pct = FEC_ON_LOSS;
        else if (pick < 78)
            r.loss_pct = LOSS_W'($urandom_range(4, 2));
        else if (pick < 92)
            r.loss_pct = LOSS_W'($urandom_range(100, 5));
        else
            r.loss_pct = LOSS_W'($urandom_range(127, 101));
        pick = $urandom_range(99);
        if (pick < 5)
            feed_time_us = {$urandom, $urandom};
        else if (pick < 12)
            feed_time_us = feed_time_us + HOLD_US + TIME_W'($urandom_range(1, 0));
        else
            feed_time_us = feed_time_us + TIME_W'($urandom_range(3000000, 0));
        r.now_us = feed_time_us;
        return r;
    endfunction

    task automatic send_report(input rpt_t r, input bit pinned, input res_t pinned_res);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            rpt_valid <= 1'b0;
            @(posedge clk);
        end
        rpt_valid <= 1'b1;
        rpt       <= r;
        pin_valid <= pinned;
        pin_res   <= pinned_res;
        @(posedge clk);
        while (!rpt_ready)
            @(posedge clk);
        sent_n++;
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic wait_results_in();
        while (got_n != sent_n)
            @(posedge clk);
    endtask

    // Main sequence
    initial
    begin
        rpt_t        r;
        res_t        none;
        int unsigned ph;
        int unsigned k;
        none = '0;

        // Directed rows; expectations typed where they follow from reset values
        dir_tab.push_back(row(0,   64'd0,       1, 0, 0, 0, 8000000));
        dir_tab.push_back(row(0,   64'd2000000, 1, 0, 0, 0, 8000000));
        dir_tab.push_back(row(0,   64'd2000001, 1, 0, 0, 1, 9000000));
        dir_tab.push_back(row(1,   64'd2500000, 1, 1, 1, 1, 10000000));
        dir_tab.push_back(row(2,   64'd2600000, 1, 1, 0, 1, 9000000));
        dir_tab.push_back(row(5,   64'd2700000, 1, 1, 0, 1, 6750000));
        dir_tab.push_back(row(127, 64'd2800000, 1, 1, 0, 1, 5062500));
        dir_tab.push_back(row(100, 64'd2900000, 1, 1, 0, 1, 3796875));
        dir_tab.push_back(row(0,   64'd3000000, 1, 1, 0, 0, 3796875));
        dir_tab.push_back(row(0,   64'd3100000, 1, 1, 0, 0, 3796875));
        dir_tab.push_back(row(0,   64'd3200000, 1, 1, 0, 0, 3796875));
        dir_tab.push_back(row(0,   64'd3300000, 1, 1, 0, 0, 3796875));
        // fifth clean report turns FEC off; sixth keeps the counter saturated
        dir_tab.push_back(row(0,   64'd3400000, 1, 0, 1, 0, 3796875));
        dir_tab.push_back(row(0,   64'd3500000, 1, 0, 0, 0, 3796875));
        dir_tab.push_back(row(0,   64'd4900001, 1, 0, 0, 1, 4796875));
        dir_tab.push_back(row(3,   64'd5000000, 1, 1, 1, 1, 4317188));
        // time running backwards reads as a long gap
        dir_tab.push_back(row(0,   64'd0,       1, 1, 0, 1, 5317188));
        dir_tab.push_back(row(4,   64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 0, 1, 4785470));
        // elapsed across the 64-bit wrap: exactly the hold, then one past it
        dir_tab.push_back(row(0,   64'd1999999, 1, 1, 0, 0, 4785470));
        dir_tab.push_back(row(0,   64'd2000000, 1, 1, 0, 1, 5785470));
        dir_tab.push_back(row(64,  64'd2100000, 1, 1, 0, 1, 4339103));
        // heavy losses down toward the min clamp
        dir_tab.push_back(row(5,   64'd2200000, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(99,  64'd2300000, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(6,   64'd2400000, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(50,  64'd2500000, 0, 0, 0, 0, 0));
        feed_time_us = 64'd2500000;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 3)
            begin
                tx_idle_pct  = 28;
                rx_stall_pct = 55;
            end
            else if (ph < 6)
            begin
                tx_idle_pct  = 55;
                rx_stall_pct = 28;
            end
            else
            begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end

            if (ph == 0)
            begin
                foreach (dir_tab[i])
                begin
                    r.loss_pct = dir_tab[i].loss;
                    r.now_us   = dir_tab[i].now;
                    send_report(r, dir_tab[i].pinned, dir_tab[i].want);
                end
            end
            else
            begin
                // registers change only with nothing in flight
                rpt_valid <= 1'b0;
                wait_results_in();
                case (ph)
                    1:
                    begin
                        write_reg(CFG_MIN_RATE, '0);
                        write_reg(CFG_MAX_RATE, RATE_TOP);
                        write_reg(CFG_START_RATE, RATE_TOP);
                    end
                    2:
                    begin
                        // min above max: min wins
                        write_reg(CFG_MIN_RATE, 30'd1000000);
                        write_reg(CFG_MAX_RATE, 30'd500000);
                        write_reg(CFG_START_RATE, 30'd700000);
                    end
                    3:
                    begin
                        write_reg(CFG_START_RATE, '0);
                        write_reg(CFG_MIN_RATE, 30'd3000000);
                        write_reg(CFG_MAX_RATE, 30'd3000000);
                        feed_time_us = 64'hFFFF_FFFF_FFE0_0000;
                    end
                    4:
                    begin
                        // tiny rates: zero deadband, step of one
                        write_reg(CFG_MIN_RATE, '0);
                        write_reg(CFG_MAX_RATE, 30'd39);
                        write_reg(CFG_START_RATE, 30'd1);
                    end
                    5:
                    begin
                        write_reg(CFG_MIN_RATE, RATE_TOP);
                        write_reg(CFG_MAX_RATE, RATE_TOP);
                        write_reg(CFG_START_RATE, 30'd123456789);
                        feed_time_us = {$urandom, $urandom};
                    end
                    6:
                    begin
                        write_reg(CFG_MIN_RATE, RATE_W'($urandom_range(2000000, 0)));
                        write_reg(CFG_SPARE, RATE_W'($urandom_range(1000000000, 0)));
                        write_reg(CFG_MAX_RATE, RATE_W'($urandom_range(1000000000, 5000000)));
                        write_reg(CFG_START_RATE, RATE_W'($urandom_range(1000000000, 0)));
                    end
                    7:
                    begin
                        write_reg(CFG_MIN_RATE, '0);
                        write_reg(CFG_MAX_RATE, 30'h15555555);
                        write_reg(CFG_START_RATE, 30'h2AAAAAAA);
                    end
                    default:
                    begin
                        write_reg(CFG_MIN_RATE, RESET_MIN_RATE);
                        write_reg(CFG_MAX_RATE, RESET_MAX_RATE);
                        write_reg(CFG_START_RATE, RESET_START_RATE);
                    end
                endcase
                cfg_valid <= 1'b0;
            end

            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                // one mid-phase pause until every owed result is back
                if (ph == 4 && k == PHASE_ITEMS / 2)
                begin
                    rpt_valid <= 1'b0;
                    wait_results_in();
                end
                send_report(next_random_report(), 1'b0, none);
            end
        end

        // drain, then let the pipeline settle
        rpt_valid <= 1'b0;
        wait_results_in();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_cnt == 0 && owed_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
